### design/apdc_pkg.sv
package apdc_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_ROOT = 2'd1;
  localparam logic [1:0] MODE_DESC = 2'd2;
  localparam logic [1:0] MODE_NOP = 2'd3;

  localparam logic [2:0] KIND_MEM = 3'd0;
  localparam logic [2:0] KIND_IO = 3'd1;
  localparam logic [2:0] KIND_MSR = 3'd2;
  localparam logic [2:0] KIND_INSN = 3'd3;
  localparam logic [2:0] KIND_SVST = 3'd4;
  localparam logic [2:0] KIND_NONE = 3'd7;

  localparam logic [3:0] C_NONE = 4'd0;
  localparam logic [3:0] C_DUP_ROOT = 4'd1;
  localparam logic [3:0] C_UNKNOWN = 4'd2;
  localparam logic [3:0] C_OVERLAP = 4'd3;
  localparam logic [3:0] C_STRICT = 4'd4;
  localparam logic [3:0] C_DUP_KEY = 4'd5;
  localparam logic [3:0] C_BAD_ATTR = 4'd6;
  localparam logic [3:0] C_COND = 4'd7;
  localparam logic [3:0] C_RESERVED = 4'd8;
  localparam logic [3:0] C_SIZE = 4'd9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [63:0] start;
    logic [63:0] len;
    logic        strict;
  } entry_t;

  // Compare of a stored entry against the new descriptor; returns a cause or C_NONE.
  function automatic logic [3:0] cmp_entry(input logic [2:0] kind, input entry_t e,
                                           input logic [63:0] a2, input logic [63:0] l2);
    logic [64:0] s1;
    logic [64:0] s2;
    logic [64:0] e1;
    logic [64:0] e2;
    logic [3:0]  r;
    s1 = {1'b0, e.start} + {1'b0, e.len};
    s2 = {1'b0, a2} + {1'b0, l2};
    e1 = s1 - 65'd1;
    e2 = s2 - 65'd1;
    r = C_NONE;
    if (kind == KIND_INSN || kind == KIND_SVST) begin
      if (e.start == a2) r = C_DUP_KEY;
    end else if (kind == KIND_IO && e.strict) begin
      if (a2 <= e.start && s2 >= s1) r = C_STRICT;
    end else begin
      if (e.len == 64'd0 || l2 == 64'd0 || e1[64] || e2[64]) r = C_SIZE;
      else if (e.start <= e2[63:0] && a2 <= e1[63:0]) r = C_OVERLAP;
    end
    return r;
  endfunction

endpackage

### design/apdc_cell.sv
module apdc_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  logic                 shift,
  input  apdc_pkg::entry_t     prev_entry,
  input  logic                 prev_vld,
  output apdc_pkg::entry_t     entry_r,
  output logic                 vld_r
);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b0;
    end else if (shift) begin
      vld_r <= prev_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      entry_r <= prev_entry;
    end
  end

endmodule

### design/access_policy_descriptor_checker.sv
// Checks an access policy one item per start pulse; busy is high while the item is worked.
// A start or root item passes the scan state once, then the done state. A descriptor
// item first scans the stored entries, which sit in a ring of cells that rotates once
// past a single comparator, one entry per cycle; a full store holds 64 entries.
// The result is shown for one cycle on out_valid; the receiver cannot stall it.
module access_policy_descriptor_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [2:0]  in_root_type,
  input  logic [63:0] in_address,
  input  logic [63:0] in_length,
  input  logic        in_strict_width,
  input  logic        in_attr_read,
  input  logic        in_attr_cond_read,
  input  logic        in_attr_write,
  input  logic        in_attr_cond_write,
  input  logic        in_is_unconditional,
  input  logic        in_reserved_nonzero,
  output logic        out_valid,
  output logic        out_verdict,
  output logic [3:0]  out_cause,
  output logic        out_entry_full
);

  localparam int N = apdc_pkg::MAX_ENTRIES;

  apdc_pkg::state_t state_r, state_nxt;
  logic [apdc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [apdc_pkg::CNT_W-1:0] step_r, step_nxt;
  logic [4:0] seen_r, seen_nxt;
  logic [2:0] kind_r, kind_nxt;
  logic       fail_r, fail_nxt;
  logic [3:0] cause_r, cause_nxt;
  logic       full_r, full_nxt;
  logic [3:0] hit_r, hit_nxt;
  logic [1:0] mode_r;
  logic [2:0] rtype_r;
  logic [63:0] addr_r, len_r;
  logic strict_r, rd_r, crd_r, wr_r, cwr_r, unc_r, resv_r;

  apdc_pkg::entry_t ring [N];
  logic             vld [N];
  apdc_pkg::entry_t new_entry;
  logic rotate, push, accept;
  logic [3:0] desc_cause, cmp_cause;

  assign accept = start && !busy;
  assign new_entry = '{start: addr_r, len: len_r,
                       strict: (kind_r == apdc_pkg::KIND_IO) ? strict_r : 1'b0};

  // Rotate during the scan; push the accepted entry at the tail when done.
  assign rotate = (state_r == apdc_pkg::ST_SCAN) && (step_r != cnt_r);
  assign push = (state_r == apdc_pkg::ST_SCAN) && (step_r == cnt_r) &&
                (mode_r == apdc_pkg::MODE_DESC) && !fail_r &&
                (kind_r != apdc_pkg::KIND_NONE) && (hit_r == apdc_pkg::C_NONE) &&
                (desc_cause == apdc_pkg::C_NONE) && (cnt_r < apdc_pkg::CNT_W'(N));

  // Cell 0 is the head read by the comparator and the ring's tail is cell cnt_r-1.
  // A full rotation brings the oldest entry back to the head; an accepted entry is
  // written into cell cnt_r.
  for (genvar i = 0; i < N; i++) begin : g_cell
    apdc_pkg::entry_t pe;
    logic pv;
    apdc_pkg::entry_t src;
    logic srcv;
    logic tail;
    if (i == N - 1) begin : g_last
      assign pe = 'x;
      assign pv = 1'b0;
    end else begin : g_mid
      assign pe = ring[i+1];
      assign pv = vld[i+1];
    end
    assign tail = (apdc_pkg::CNT_W'(i) == cnt_r - apdc_pkg::CNT_W'(1));
    always_comb begin
      src = pe;
      srcv = pv;
      if (rotate && tail) begin
        src = ring[0];
        srcv = vld[0];
      end
      if (push && apdc_pkg::CNT_W'(i) == cnt_r) begin
        src = new_entry;
        srcv = 1'b1;
      end
    end
    apdc_cell u_cell (
      .clk(clk), .rst_n(rst_n),
      .load(accept && in_mode != apdc_pkg::MODE_DESC),
      .shift(rotate ? (apdc_pkg::CNT_W'(i) < cnt_r)
                    : (push && apdc_pkg::CNT_W'(i) == cnt_r)),
      .prev_entry(src), .prev_vld(srcv),
      .entry_r(ring[i]), .vld_r(vld[i])
    );
  end

  assign cmp_cause = apdc_pkg::cmp_entry(kind_r, ring[0], addr_r, len_r);

  always_comb begin
    desc_cause = apdc_pkg::C_NONE;
    if (kind_r == apdc_pkg::KIND_SVST && ((wr_r | cwr_r) || (rd_r & crd_r))) begin
      desc_cause = apdc_pkg::C_BAD_ATTR;
    end else if (kind_r == apdc_pkg::KIND_SVST && !crd_r && !unc_r) begin
      desc_cause = apdc_pkg::C_COND;
    end else if (kind_r != apdc_pkg::KIND_MSR && resv_r) begin
      desc_cause = apdc_pkg::C_RESERVED;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      apdc_pkg::ST_IDLE: if (start) state_nxt = apdc_pkg::ST_SCAN;
      apdc_pkg::ST_SCAN: if (step_r == cnt_r) state_nxt = apdc_pkg::ST_DONE;
      apdc_pkg::ST_DONE: state_nxt = apdc_pkg::ST_IDLE;
      default: state_nxt = apdc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    step_nxt = step_r;
    seen_nxt = seen_r;
    kind_nxt = kind_r;
    fail_nxt = fail_r;
    cause_nxt = cause_r;
    full_nxt = full_r;
    hit_nxt = hit_r;
    if (accept) begin
      step_nxt = '0;
      hit_nxt = apdc_pkg::C_NONE;
      full_nxt = 1'b0;
      if (in_mode != apdc_pkg::MODE_DESC) step_nxt = cnt_r;
    end else if (rotate) begin
      step_nxt = step_r + apdc_pkg::CNT_W'(1);
      if (hit_r == apdc_pkg::C_NONE) hit_nxt = cmp_cause;
    end else if (state_r == apdc_pkg::ST_SCAN) begin
      if (mode_r == apdc_pkg::MODE_START) begin
        cnt_nxt = '0;
        seen_nxt = '0;
        kind_nxt = apdc_pkg::KIND_NONE;
        fail_nxt = 1'b0;
        cause_nxt = apdc_pkg::C_NONE;
      end else if (mode_r == apdc_pkg::MODE_ROOT && !fail_r) begin
        kind_nxt = apdc_pkg::KIND_NONE;
        cnt_nxt = '0;
        if (rtype_r > apdc_pkg::KIND_SVST) begin
          fail_nxt = 1'b1;
          cause_nxt = apdc_pkg::C_UNKNOWN;
        end else if (seen_r[rtype_r]) begin
          fail_nxt = 1'b1;
          cause_nxt = apdc_pkg::C_DUP_ROOT;
        end else begin
          seen_nxt[rtype_r] = 1'b1;
          if (resv_r) begin
            fail_nxt = 1'b1;
            cause_nxt = apdc_pkg::C_RESERVED;
          end else begin
            kind_nxt = rtype_r;
          end
        end
      end else if (mode_r == apdc_pkg::MODE_DESC && !fail_r &&
                   kind_r != apdc_pkg::KIND_NONE) begin
        if (hit_r != apdc_pkg::C_NONE) begin
          fail_nxt = 1'b1;
          cause_nxt = hit_r;
        end else if (desc_cause != apdc_pkg::C_NONE) begin
          fail_nxt = 1'b1;
          cause_nxt = desc_cause;
        end else if (cnt_r >= apdc_pkg::CNT_W'(N)) begin
          fail_nxt = 1'b1;
          cause_nxt = apdc_pkg::C_NONE;
          full_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + apdc_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= apdc_pkg::ST_IDLE;
      cnt_r <= '0;
      step_r <= '0;
      seen_r <= '0;
      kind_r <= apdc_pkg::KIND_NONE;
      fail_r <= 1'b0;
      cause_r <= apdc_pkg::C_NONE;
      full_r <= 1'b0;
      hit_r <= apdc_pkg::C_NONE;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      step_r <= step_nxt;
      seen_r <= seen_nxt;
      kind_r <= kind_nxt;
      fail_r <= fail_nxt;
      cause_r <= cause_nxt;
      full_r <= full_nxt;
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      rtype_r <= in_root_type;
      addr_r <= in_address;
      len_r <= in_length;
      strict_r <= in_strict_width;
      rd_r <= in_attr_read;
      crd_r <= in_attr_cond_read;
      wr_r <= in_attr_write;
      cwr_r <= in_attr_cond_write;
      unc_r <= in_is_unconditional;
      resv_r <= in_reserved_nonzero;
    end
  end

  always_comb begin
    busy = (state_r != apdc_pkg::ST_IDLE);
    out_valid = (state_r == apdc_pkg::ST_DONE);
    out_verdict = fail_r;
    out_cause = cause_r;
    out_entry_full = full_r;
  end

`ifndef SYNTHESIS
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("busy not raised after start");
  a_full_implies_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_full |-> out_verdict && out_cause == apdc_pkg::C_NONE)
    else $error("entry_full without violation");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= apdc_pkg::CNT_W'(N)) else $error("entry count out of range");
  a_clean_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !fail_r |-> cause_r == apdc_pkg::C_NONE) else $error("cause without failure");
`endif

endmodule
